// ----- sv/text_cell_console_engine_unit_defines.svh -----
// Assertion macros shared by the text console engine RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TEXT_CELL_CONSOLE_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CELL_CONSOLE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCCE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console engine check failed");

// Next-cycle implication, checked outside reset.
`define TCCE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console engine check failed");

`endif

// ----- sv/tcce_pkg.sv -----
// Package for the text console engine: grid sizes, character codes,
// operation codes, interface structs and the cell address function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  // Grid geometry of the cell store.
  localparam int MAX_COLS = 192;
  localparam int MAX_ROWS = 96;
  localparam int COL_W    = 8;
  localparam int ROW_W    = 7;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CELL_W   = 16;

  // Stream payload widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [COL_W-1:0] COLS_RST = COL_W'(80);
  localparam logic [ROW_W-1:0] ROWS_RST = ROW_W'(25);

  // Character codes.
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLS  = 2'd0;
  localparam logic [1:0] CFG_ROWS  = 2'd1;
  localparam logic [1:0] CFG_COLOR = 2'd2;

  // Operation selected by the input transaction.
  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_IBS   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  // Effective configuration seen by the sequencer.
  typedef struct packed {
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
    logic [7:0]       color;
  } cfg_t;

  // Status reported by the sequencer.
  typedef struct packed {
    logic init_done;
    logic busy;
  } sts_t;

  // Linear cell address of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(MAX_COLS);
    return base + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ----- sv/tcce_cell_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the character cells of the console; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcce_cell_ram #(
  parameter int AW    = 15,
  parameter int DW    = 16,
  parameter int DEPTH = 18432
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/tcce_seq.sv -----
// Sequencer of the text console engine: cursor, operation decode, cell
// sweeps for clear, scroll and reset fill, and the result register.
// Depends on tcce_pkg and tcce_cell_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcce_seq import tcce_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [1:0]            in_tuser,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  output sts_t                       sts
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [COL_W-1:0]        cur_x_r, cur_x_nxt;
  logic [ROW_W-1:0]        cur_y_r, cur_y_nxt;
  func_t                   fn_r, fn_nxt;
  logic [7:0]              ch_r, ch_nxt;
  logic [ROW_W-1:0]        rrow_r, rrow_nxt;
  logic [COL_W-1:0]        rcol_r, rcol_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_last_r, row_last_nxt;
  logic [COL_W-1:0]        col_last_r, col_last_nxt;
  logic                    pend_r, pend_nxt;
  logic [ADDR_W-1:0]       pend_addr_r, pend_addr_nxt;
  logic                    scr_r, scr_nxt;
  logic [7:0]              cchar_r, cchar_nxt;
  logic [7:0]              ccolor_r, ccolor_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  // Put-character decode.
  logic [COL_W:0]          tab_x;
  logic [COL_W:0]          px;
  logic [COL_W:0]          py;
  logic                    put_we;
  logic [COL_W-1:0]        put_col;
  logic [CELL_W-1:0]       put_data;
  logic                    put_scroll;

  // Interactive backspace decode.
  logic                    ibs_act;
  logic [COL_W-1:0]        ibs_x;
  logic [ROW_W-1:0]        ibs_y;

  // Shared address unit and memory port signals.
  logic [ROW_W-1:0]        a_row;
  logic [COL_W-1:0]        a_col;
  logic [ADDR_W-1:0]       addr;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [CELL_W-1:0]       mem_wdata;
  logic                    mem_re;
  logic [CELL_W-1:0]       mem_rdata;

  logic                    read_ok;
  logic                    sweep_end;
  logic [CELL_W-1:0]       blank;

  assign blank     = {cfg.color, BLANK_CHAR};
  assign read_ok   = ({1'b0, rrow_r} < (ROW_W+1)'(MAX_ROWS)) &&
                     ({1'b0, rcol_r} < (COL_W+1)'(MAX_COLS));
  assign sweep_end = (row_r == row_last_r) && (col_r == col_last_r);

  // Put character: controls, write at cursor, wrap and scroll test.
  always_comb begin
    px       = {1'b0, cur_x_r};
    py       = (COL_W+1)'(cur_y_r);
    put_we   = 1'b0;
    put_col  = cur_x_r;
    put_data = {cfg.color, ch_r};
    tab_x    = ({1'b0, cur_x_r} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
    case (ch_r)
      CH_LF: begin
        px = '0;
        py = py + (COL_W+1)'(1);
      end
      CH_CR: begin
        px = '0;
      end
      CH_BS: begin
        if (cur_x_r != '0) begin
          px       = px - (COL_W+1)'(1);
          put_we   = 1'b1;
          put_col  = cur_x_r - COL_W'(1);
          put_data = blank;
        end
      end
      CH_TAB: begin
        if (tab_x >= {1'b0, cfg.cols}) begin
          px = '0;
          py = py + (COL_W+1)'(1);
        end else begin
          px = tab_x;
        end
      end
      default: begin
        put_we = 1'b1;
        px     = px + (COL_W+1)'(1);
      end
    endcase
    if (px >= {1'b0, cfg.cols}) begin
      px = '0;
      py = py + (COL_W+1)'(1);
    end
    put_scroll = (py >= (COL_W+1)'(cfg.rows));
    if (put_scroll) begin
      py = (COL_W+1)'(cfg.rows - ROW_W'(1));
    end
  end

  // Interactive backspace crosses to the end of the previous row.
  always_comb begin
    ibs_act = (cur_x_r != '0) || (cur_y_r != '0);
    ibs_x   = cur_x_r;
    ibs_y   = cur_y_r;
    if (cur_x_r != '0) begin
      ibs_x = cur_x_r - COL_W'(1);
    end else if (cur_y_r != '0) begin
      ibs_y = cur_y_r - ROW_W'(1);
      ibs_x = cfg.cols - COL_W'(1);
    end
  end

  // Address unit input selection.
  always_comb begin
    a_row = row_r;
    a_col = col_r;
    if (state_r == ST_EXEC) begin
      case (fn_r)
        FN_PUT: begin
          a_row = cur_y_r;
          a_col = put_col;
        end
        FN_IBS: begin
          a_row = ibs_y;
          a_col = ibs_x;
        end
        FN_READ: begin
          a_row = rrow_r;
          a_col = rcol_r;
        end
        default: begin
          a_row = row_r;
          a_col = col_r;
        end
      endcase
    end
  end

  assign addr = cell_addr(a_row, a_col);

  // Memory ports; a pending scroll copy owns the write port.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = blank;
    mem_re    = 1'b0;
    if (pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = mem_rdata;
    end else begin
      case (state_r)
        ST_INIT: begin
          mem_we    = 1'b1;
          mem_wdata = {8'h00, BLANK_CHAR};
        end
        ST_EXEC: begin
          if (fn_r == FN_PUT) begin
            mem_we    = put_we;
            mem_wdata = put_data;
          end else if (fn_r == FN_IBS) begin
            mem_we = ibs_act;
          end
        end
        ST_BLANK, ST_CLEAR: begin
          mem_we = 1'b1;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
    if ((state_r == ST_COPY) || ((state_r == ST_EXEC) && (fn_r == FN_READ) && read_ok)) begin
      mem_re = 1'b1;
    end
  end

  tcce_cell_ram #(
    .AW    (ADDR_W),
    .DW    (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    fn_nxt        = fn_r;
    ch_nxt        = ch_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    row_last_nxt  = row_last_r;
    col_last_nxt  = col_last_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    scr_nxt       = scr_r;
    cchar_nxt     = cchar_r;
    ccolor_nxt    = ccolor_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    // Sweep counter step, used by every sweep state.
    if (col_r == col_last_r) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
    end

    case (state_r)
      ST_INIT: begin
        if (sweep_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        row_nxt = row_r;
        col_nxt = col_r;
        if (in_tvalid) begin
          fn_nxt    = func_t'(in_tuser);
          ch_nxt    = in_tdata[7:0];
          rrow_nxt  = in_tdata[14:8];
          rcol_nxt  = in_tdata[22:15];
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        scr_nxt    = 1'b0;
        cchar_nxt  = '0;
        ccolor_nxt = '0;
        state_nxt  = ST_DONE;
        col_nxt    = '0;
        col_last_nxt = cfg.cols - COL_W'(1);
        row_last_nxt = cfg.rows - ROW_W'(1);
        case (fn_r)
          FN_PUT: begin
            cur_x_nxt = px[COL_W-1:0];
            cur_y_nxt = py[ROW_W-1:0];
            scr_nxt   = put_scroll;
            if (put_scroll) begin
              if (cfg.rows == ROW_W'(1)) begin
                row_nxt   = '0;
                state_nxt = ST_BLANK;
              end else begin
                row_nxt   = ROW_W'(1);
                state_nxt = ST_COPY;
              end
            end
          end
          FN_IBS: begin
            cur_x_nxt = ibs_x;
            cur_y_nxt = ibs_y;
          end
          FN_CLEAR: begin
            cur_x_nxt = '0;
            cur_y_nxt = '0;
            row_nxt   = '0;
            state_nxt = ST_CLEAR;
          end
          FN_READ: begin
            if (read_ok) begin
              state_nxt = ST_READ_WAIT;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_READ_WAIT: begin
        cchar_nxt  = mem_rdata[7:0];
        ccolor_nxt = mem_rdata[15:8];
        state_nxt  = ST_DONE;
      end
      ST_COPY: begin
        // Read one row down, write it back one row up next cycle.
        pend_nxt      = 1'b1;
        pend_addr_nxt = addr - ADDR_W'(MAX_COLS);
        if (sweep_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        row_nxt   = row_last_r;
        col_nxt   = '0;
        state_nxt = ST_BLANK;
      end
      ST_BLANK, ST_CLEAR: begin
        if (sweep_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        row_nxt = row_r;
        col_nxt = col_r;
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ccolor_r, cchar_r, scr_r, cur_y_r, cur_x_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, cursor and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      row_last_r  <= ROW_W'(MAX_ROWS - 1);
      col_last_r  <= COL_W'(MAX_COLS - 1);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      row_last_r  <= row_last_nxt;
      col_last_r  <= col_last_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      fn_r        <= fn_nxt;
      ch_r        <= ch_nxt;
      rrow_r      <= rrow_nxt;
      rcol_r      <= rcol_nxt;
      pend_addr_r <= pend_addr_nxt;
      scr_r       <= scr_nxt;
      cchar_r     <= cchar_nxt;
      ccolor_r    <= ccolor_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign in_tready     = (state_r == ST_IDLE);
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign sts.init_done = (state_r != ST_INIT);
  assign sts.busy      = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ----- sv/text_cell_console_engine_unit.sv -----
// Top level of the text console engine: configuration registers with
// clamping, the sequencer and interface checks.
// Depends on tcce_pkg, tcce_seq and the shared assertion macro header.
//
//   Channel   Direction  Handshake             Payload
//   in_       slave      in_tvalid/in_tready   tuser func, tdata char/row/col
//   out_      master     out_tvalid/out_tready tdata cursor, scrolled, cell
//   cfg_      slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A put character that does not scroll, interactive backspace and a read outside the store
// go through accept, execute and load result; a read inside the store adds a read wait.
// A scroll adds a copy pass and drain step if rows > 1, then blanks the bottom row; clear
// sweeps all active cells. After reset a fill pass writes all 18432 cells, one per cycle.
// One item is accepted while a result waits in the output register; the next result then
// waits until that one is taken. Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "text_cell_console_engine_unit_defines.svh"

module text_cell_console_engine_unit import tcce_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input items.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [1:0]            in_tuser,   // [1:0] func
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] char_code, [14:8] read_row,
                                                 // [22:15] read_col, [23] zero
  // Result items.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [7:0] cursor_col, [14:8] cursor_row,
                                                 // [15] scrolled, [23:16] cell_char,
                                                 // [31:24] cell_color
  // Configuration writes.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);

  logic [COL_W-1:0] cols_r, cols_nxt;
  logic [ROW_W-1:0] rows_r, rows_nxt;
  logic [7:0]       color_r, color_nxt;
  cfg_t             cfg;
  sts_t             sts;

  assign cfg_ready = 1'b1;

  // Register writes, clamped to the usable grid.
  always_comb begin
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    color_nxt = color_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLS: begin
          if (cfg_data == '0) begin
            cols_nxt = COL_W'(1);
          end else if ({1'b0, cfg_data} > (COL_W+1)'(MAX_COLS)) begin
            cols_nxt = COL_W'(MAX_COLS);
          end else begin
            cols_nxt = cfg_data;
          end
        end
        CFG_ROWS: begin
          if (cfg_data[ROW_W-1:0] == '0) begin
            rows_nxt = ROW_W'(1);
          end else if ({1'b0, cfg_data[ROW_W-1:0]} > (ROW_W+1)'(MAX_ROWS)) begin
            rows_nxt = ROW_W'(MAX_ROWS);
          end else begin
            rows_nxt = cfg_data[ROW_W-1:0];
          end
        end
        CFG_COLOR: begin
          color_nxt = cfg_data;
        end
        default: begin
          color_nxt = color_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= COLS_RST;
      rows_r  <= ROWS_RST;
      color_r <= '0;
    end else begin
      cols_r  <= cols_nxt;
      rows_r  <= rows_nxt;
      color_r <= color_nxt;
    end
  end

  assign cfg.cols  = cols_r;
  assign cfg.rows  = rows_r;
  assign cfg.color = color_r;

  tcce_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .sts        (sts)
  );

  // No item is taken before the reset fill pass has finished.
  `TCCE_ASSERT_IMP(a_no_accept_in_fill, !sts.init_done, !in_tready)
  // An accepted item keeps the input closed while it is worked on.
  `TCCE_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready && sts.busy)
  // A scrolling result leaves the cursor on the last active row.
  `TCCE_ASSERT_IMP(a_scroll_last_row, out_tvalid && out_tdata[15],
                   out_tdata[14:8] == (rows_r - ROW_W'(1)))

endmodule

`default_nettype wire

// ----- verif/text_cell_console_engine_unit_tb.sv -----
// Self-checking testbench for the text console engine: a directed table, then random
// phases over several grid sizes, checked against a cycle-free model of the cell grid.
// Depends on tcce_pkg and text_cell_console_engine_unit.
`timescale 1ns / 1ps

module text_cell_console_engine_unit_tb;
  import tcce_pkg::*;

  // One input transaction, fields as they travel on in_tuser and in_tdata.
  typedef struct packed {
    func_t      op;
    logic [7:0] ch;
    logic [6:0] rd_row;
    logic [7:0] rd_col;
  } console_item_t;

  // One result transaction, laid out exactly as out_tdata (lowest field last).
  typedef struct packed {
    logic [7:0] cell_color;
    logic [7:0] cell_char;
    logic       scrolled;
    logic [6:0] cursor_row;
    logic [7:0] cursor_col;
  } console_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One line of the directed table: an item or a register write.
  typedef struct packed {
    row_kind_t       kind;
    console_item_t   item;
    logic [1:0]      reg_idx;
    logic [7:0]      reg_val;
    logic            typed;
    console_result_t result;
  } plan_row_t;

  localparam console_result_t NO_RESULT = '0;
  localparam console_item_t   NO_ITEM   = '{FN_PUT, 8'h00, 7'd0, 8'd0};

  // Random phases with fixed grid settings; later phases pick sizes at random.
  localparam int PH_HOME_SIZE = 0;
  localparam int PH_MAX_CLAMP = 1;
  localparam int PH_MIN_CLAMP = 2;
  localparam int PH_OVER_BY_1 = 3;
  localparam int PH_FULL_GRID = 4;

  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [1:0]            in_tuser  = '0;   // [1:0] func
  logic [IN_DATA_W-1:0]  in_tdata  = '0;   // [7:0] char_code, [14:8] read_row,
                                           // [22:15] read_col, [23] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [7:0] cursor_col, [14:8] cursor_row,
                                           // [15] scrolled, [23:16] cell_char,
                                           // [31:24] cell_color
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [7:0]            cfg_data  = '0;

  // Model of the block: cell grid, cursor and raw register values.
  logic [15:0]      shadow_grid [CELLS];
  int unsigned      cur_x;
  int unsigned      cur_y;
  logic [COL_W-1:0] cols_reg;
  logic [ROW_W-1:0] rows_reg;
  logic [7:0]       color_reg;

  console_result_t  pending_results [$];
  int               mismatch_count = 0;
  bit               sender_burst   = 1'b0;

  // Directed items, with the result typed in where it is obvious.
  plan_row_t directed_plan [29] = '{
    '{ROW_ITEM, '{FN_READ, 8'h00, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cell_char: BLANK_CHAR, default: '0}},
    '{ROW_ITEM, '{FN_READ, 8'h00, 7'd95, 8'd191}, CFG_COLS, 8'd0, 1'b1,
      '{cell_char: BLANK_CHAR, default: '0}},
    '{ROW_ITEM, '{FN_READ, 8'h00, 7'd127, 8'd255}, CFG_COLS, 8'd0, 1'b1, NO_RESULT},
    '{ROW_ITEM, '{FN_READ, 8'h00, 7'd0, 8'd192}, CFG_COLS, 8'd0, 1'b1, NO_RESULT},
    '{ROW_ITEM, '{FN_IBS, 8'h00, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1, NO_RESULT},
    '{ROW_ITEM, '{FN_PUT, 8'h41, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_col: 8'd1, default: '0}},
    '{ROW_ITEM, '{FN_PUT, 8'hFF, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_col: 8'd2, default: '0}},
    '{ROW_ITEM, '{FN_PUT, 8'h00, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_col: 8'd3, default: '0}},
    '{ROW_ITEM, '{FN_PUT, CH_BS, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_col: 8'd2, default: '0}},
    '{ROW_ITEM, '{FN_PUT, CH_TAB, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_col: 8'd4, default: '0}},
    '{ROW_ITEM, '{FN_PUT, CH_TAB, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_col: 8'd8, default: '0}},
    '{ROW_ITEM, '{FN_PUT, CH_CR, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1, NO_RESULT},
    '{ROW_ITEM, '{FN_PUT, CH_LF, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_row: 7'd1, default: '0}},
    '{ROW_ITEM, '{FN_PUT, CH_BS, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_row: 7'd1, default: '0}},
    '{ROW_ITEM, '{FN_IBS, 8'h00, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b1,
      '{cursor_col: 8'd79, default: '0}},
    '{ROW_ITEM, '{FN_READ, 8'h00, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b0, NO_RESULT},
    // Shrink the grid so that the cursor lies outside it.
    '{ROW_REG, NO_ITEM, CFG_COLS, 8'd6, 1'b0, NO_RESULT},
    '{ROW_REG, NO_ITEM, CFG_ROWS, 8'd2, 1'b0, NO_RESULT},
    '{ROW_REG, NO_ITEM, CFG_COLOR, 8'hA5, 1'b0, NO_RESULT},
    '{ROW_ITEM, '{FN_PUT, 8'h5A, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '{FN_PUT, CH_TAB, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '{FN_PUT, CH_TAB, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '{FN_READ, 8'h00, 7'd0, 8'd79}, CFG_COLS, 8'd0, 1'b0, NO_RESULT},
    // Single row, over-wide column count.
    '{ROW_REG, NO_ITEM, CFG_ROWS, 8'd0, 1'b0, NO_RESULT},
    '{ROW_REG, NO_ITEM, CFG_COLS, 8'd255, 1'b0, NO_RESULT},
    '{ROW_ITEM, '{FN_PUT, CH_LF, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '{FN_READ, 8'h00, 7'd0, 8'd79}, CFG_COLS, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '{FN_IBS, 8'h00, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '{FN_CLEAR, 8'h00, 7'd0, 8'd0}, CFG_COLS, 8'd0, 1'b0, NO_RESULT}
  };

  text_cell_console_engine_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Register values as the block clamps them.
  function automatic int unsigned grid_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  function automatic int unsigned grid_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic void store_cell(int unsigned row, int unsigned col, logic [15:0] v);
    if (row < MAX_ROWS && col < MAX_COLS) shadow_grid[row * MAX_COLS + col] = v;
  endfunction

  // Applies one operation to the model and returns the result it produces.
  function automatic console_result_t apply_console_op(console_item_t it);
    console_result_t res;
    int unsigned     cols;
    int unsigned     rows;
    int unsigned     x;
    int unsigned     y;
    int unsigned     i;
    int unsigned     j;
    logic [15:0]     blank;
    logic [15:0]     v;
    res   = '0;
    cols  = grid_cols();
    rows  = grid_rows();
    blank = {color_reg, BLANK_CHAR};
    case (it.op)
      FN_PUT: begin
        x = cur_x;
        y = cur_y;
        case (it.ch)
          CH_LF: begin
            x = 0;
            y++;
          end
          CH_CR: x = 0;
          CH_BS: begin
            if (x > 0) begin
              x--;
              store_cell(y, x, blank);
            end
          end
          CH_TAB: begin
            x = (x + 4) & ~32'd3;
            if (x >= cols) begin
              x = 0;
              y++;
            end
          end
          default: begin
            store_cell(y, x, {color_reg, it.ch});
            x++;
          end
        endcase
        if (x >= cols) begin
          x = 0;
          y++;
        end
        // Past the last row: move the active grid up and blank the bottom row.
        if (y >= rows) begin
          for (i = 1; i < rows; i++)
            for (j = 0; j < cols; j++)
              shadow_grid[(i - 1) * MAX_COLS + j] = shadow_grid[i * MAX_COLS + j];
          for (j = 0; j < cols; j++) shadow_grid[(rows - 1) * MAX_COLS + j] = blank;
          y = rows - 1;
          res.scrolled = 1'b1;
        end
        cur_x = x;
        cur_y = y;
      end
      FN_IBS: begin
        if (cur_x != 0 || cur_y != 0) begin
          if (cur_x > 0) begin
            cur_x--;
          end else begin
            cur_y--;
            cur_x = cols - 1;
          end
          store_cell(cur_y, cur_x, blank);
        end
      end
      FN_CLEAR: begin
        for (i = 0; i < rows; i++)
          for (j = 0; j < cols; j++) shadow_grid[i * MAX_COLS + j] = blank;
        cur_x = 0;
        cur_y = 0;
      end
      default: begin
        if (it.rd_row < MAX_ROWS && it.rd_col < MAX_COLS) begin
          v = shadow_grid[it.rd_row * MAX_COLS + it.rd_col];
          res.cell_char  = v[7:0];
          res.cell_color = v[15:8];
        end
      end
    endcase
    res.cursor_col = cur_x[7:0];
    res.cursor_row = cur_y[6:0];
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Random item, weighted toward characters and reads of the active area.
  function automatic console_item_t random_item();
    console_item_t it;
    int unsigned   r;
    it.op     = FN_PUT;
    it.ch     = 8'($urandom);
    it.rd_row = 7'($urandom);
    it.rd_col = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 58) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        case ($urandom_range(0, 3))
          0:       it.ch = CH_LF;
          1:       it.ch = CH_CR;
          2:       it.ch = CH_BS;
          default: it.ch = CH_TAB;
        endcase
      end else if (r < 8) begin
        it.ch = 8'($urandom_range(8'h20, 8'h7E));
      end
    end else if (r < 70) begin
      it.op = FN_IBS;
    end else if (r < 73) begin
      it.op = FN_CLEAR;
    end else begin
      it.op = FN_READ;
      if ($urandom_range(0, 4) != 0) begin
        it.rd_row = 7'($urandom_range(0, grid_rows() - 1));
        it.rd_col = 8'($urandom_range(0, grid_cols() - 1));
      end
    end
    return it;
  endfunction

  // Offers one item, records its expected result once the transaction is taken.
  task automatic send_item(input console_item_t it, input bit typed,
                           input console_result_t typed_res);
    console_result_t want;
    int              gap;
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {1'b0, it.rd_col, it.rd_row, it.ch};
    do @(posedge clk); while (!in_tready);
    want = apply_console_op(it);
    pending_results.push_back(typed ? typed_res : want);
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write, issued only once every pending result has come out.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COLS:  cols_reg  = val;
      CFG_ROWS:  rows_reg  = val[ROW_W-1:0];
      CFG_COLOR: color_reg = val;
      default: ;
    endcase
  endtask

  // Input side: reset, directed table, random phases, then the verdict.
  initial begin : stimulus_side
    console_item_t it;
    int            phase;
    int            n_items;
    int            random_items;
    logic [7:0]    new_cols;
    logic [7:0]    new_rows;
    logic [7:0]    new_color;
    for (int k = 0; k < CELLS; k++) shadow_grid[k] = {8'h00, BLANK_CHAR};
    cur_x     = 0;
    cur_y     = 0;
    cols_reg  = COLS_RST;
    rows_reg  = ROWS_RST;
    color_reg = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG)
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      else
        send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].result);
    end

    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      n_items   = $urandom_range(20, 80);
      new_color = 8'($urandom);
      case (phase)
        PH_HOME_SIZE: begin
          new_cols  = COLS_RST;
          new_rows  = ROWS_RST;
          new_color = 8'h00;
          n_items   = 100;
        end
        PH_MAX_CLAMP: begin
          new_cols  = 8'd255;
          new_rows  = 8'd127;
          new_color = 8'hFF;
          n_items   = 10;
        end
        PH_MIN_CLAMP: begin
          new_cols = 8'd0;
          new_rows = 8'd0;
          n_items  = 20;
        end
        PH_OVER_BY_1: begin
          new_cols = 8'(MAX_COLS + 1);
          new_rows = 8'(MAX_ROWS + 1);
          n_items  = 10;
        end
        PH_FULL_GRID: begin
          new_cols = 8'(MAX_COLS);
          new_rows = 8'(MAX_ROWS);
          n_items  = 10;
        end
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            new_cols = 8'($urandom_range(13, 40));
            new_rows = 8'($urandom_range(6, 20));
          end else begin
            new_cols = 8'($urandom_range(1, 12));
            new_rows = 8'($urandom_range(1, 6));
          end
        end
      endcase
      write_reg(CFG_COLS, new_cols);
      write_reg(CFG_ROWS, new_rows);
      write_reg(CFG_COLOR, new_color);
      sender_burst = ($urandom_range(0, 3) == 0);

      // On the largest grid, walk the cursor to the bottom so a full scroll happens.
      if (phase == PH_MAX_CLAMP) begin
        repeat (MAX_ROWS) begin
          it        = random_item();
          it.op     = FN_PUT;
          it.ch     = CH_LF;
          send_item(it, 1'b0, NO_RESULT);
          random_items++;
        end
      end
      repeat (n_items) begin
        send_item(random_item(), 1'b0, NO_RESULT);
        random_items++;
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: checks each result transaction and paces out_tready.
  initial begin : result_side
    console_result_t got;
    console_result_t want;
    int              stall_left;
    int              taken;
    stall_left = 0;
    taken      = 0;
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = console_result_t'(out_tdata);
        taken++;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: out_tdata %h", out_tdata);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, actual %0d", want.cursor_col, got.cursor_col);
            mismatch_count++;
          end
          if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, actual %0d", want.cursor_row, got.cursor_row);
            mismatch_count++;
          end
          if (got.scrolled !== want.scrolled) begin
            $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
            mismatch_count++;
          end
          if (got.cell_char !== want.cell_char) begin
            $error("cell_char: expected %h, actual %h", want.cell_char, got.cell_char);
            mismatch_count++;
          end
          if (got.cell_color !== want.cell_color) begin
            $error("cell_color: expected %h, actual %h", want.cell_color, got.cell_color);
            mismatch_count++;
          end
        end
      end

      // A long hold once, so the block backs up into its input; otherwise random gaps, or none.
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_tready <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        if (taken == HOLD_AT) stall_left = HOLD_CYCLES;
        else if ((taken / 200) % 3 == 2) stall_left = 0;
        else stall_left = pick_gap();
        if (stall_left > 0) out_tready <= 1'b0;
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/tcce_pkg.sv
sv/tcce_cell_ram.sv
sv/tcce_seq.sv
sv/text_cell_console_engine_unit.sv
verif/text_cell_console_engine_unit_tb.sv
